@@ rtl/pngc_pkg.sv @@
// Package for the PNG chunk stream assembler.
// Holds CRC-32 helpers, fixed chunk checksums, register codes and reset values.
// No dependencies.
`default_nettype none

package pngc_pkg;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

  // One byte of the reflected CRC-32 register update
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h00_0000, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Four bytes, most significant first; used for elaboration-time constants
  function automatic logic [31:0] crc_word(logic [31:0] crc, logic [31:0] w);
    logic [31:0] c;
    c = crc_byte(crc, w[31:24]);
    c = crc_byte(c, w[23:16]);
    c = crc_byte(c, w[15:8]);
    c = crc_byte(c, w[7:0]);
    return c;
  endfunction

  // Chunk type tags
  localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
  localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
  localparam logic [31:0] TAG_IEND = 32'h4945_4E44;

  // Fixed chunk checksums (sRGB 0, gAMA 45455, pHYs 3779/3779/metre, IEND)
  localparam logic [31:0] SRGB_CRC = 32'hAECE_1CE9;
  localparam logic [31:0] GAMA_CRC = 32'h0BFC_6105;
  localparam logic [31:0] PHYS_CRC = 32'hC76F_A864;
  localparam logic [31:0] IEND_CRC = 32'hAE42_6082;

  // CRC register after the type tag of a chunk
  localparam logic [31:0] CRC_AFTER_IHDR = crc_word(CRC_ALL_ONES, TAG_IHDR);
  localparam logic [31:0] CRC_AFTER_IDAT = crc_word(CRC_ALL_ONES, TAG_IDAT);

  // Configuration register widths and reset values
  localparam int unsigned DIM_W    = 31;
  localparam int unsigned DEPTH_W  = 5;
  localparam int unsigned COLOUR_W = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH    = 31'd1;
  localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT   = 31'd1;
  localparam logic [DEPTH_W-1:0]  RST_SAMPLE_DEPTH   = 5'd8;
  localparam logic [COLOUR_W-1:0] RST_COLOUR_KIND    = 3'd6;
  localparam logic [DIM_W-1:0]    RST_PAYLOAD_LENGTH = 31'd1;

  // IHDR checksum for the reset configuration
  localparam logic [31:0] RST_IHDR_CRC = crc_byte(
      crc_word(crc_word(crc_word(CRC_AFTER_IHDR, {1'b0, RST_IMAGE_WIDTH}),
                        {1'b0, RST_IMAGE_HEIGHT}),
               {3'b000, RST_SAMPLE_DEPTH, 5'b00000, RST_COLOUR_KIND, 16'h0000}),
      8'h00) ^ CRC_ALL_ONES;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH    = 3'd0,
    REG_IMAGE_HEIGHT   = 3'd1,
    REG_SAMPLE_DEPTH   = 3'd2,
    REG_COLOUR_KIND    = 3'd3,
    REG_PAYLOAD_LENGTH = 3'd4
  } cfg_reg_e;

  // Status of the IHDR checksum unit
  typedef struct packed {
    logic        busy;
    logic [31:0] crc;
  } ihdr_crc_t;

endpackage

`default_nettype wire

@@ rtl/pngc_ihdr_crc.sv @@
// IHDR checksum unit: rebuilds the IHDR CRC-32 one data byte per cycle
// after a write to a header field. Depends on pngc_pkg.
`default_nettype none

module pngc_ihdr_crc
  import pngc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [DIM_W-1:0]    image_width_i,
  input  wire logic [DIM_W-1:0]    image_height_i,
  input  wire logic [DEPTH_W-1:0]  sample_depth_i,
  input  wire logic [COLOUR_W-1:0] colour_kind_i,
  output ihdr_crc_t                status_o
);

  localparam logic [3:0] LAST_BYTE = 4'd12;  // thirteen IHDR data bytes

  logic        busy_q;
  logic [3:0]  cnt_q;
  logic [31:0] crc_q;
  logic [31:0] result_q;
  logic [7:0]  data_byte;
  logic [31:0] crc_next;
  logic [31:0] width32;
  logic [31:0] height32;

  assign width32  = {1'b0, image_width_i};
  assign height32 = {1'b0, image_height_i};

  // Pick the IHDR data byte at the current position
  always_comb begin
    case (cnt_q)
      4'd0:    data_byte = width32[31:24];
      4'd1:    data_byte = width32[23:16];
      4'd2:    data_byte = width32[15:8];
      4'd3:    data_byte = width32[7:0];
      4'd4:    data_byte = height32[31:24];
      4'd5:    data_byte = height32[23:16];
      4'd6:    data_byte = height32[15:8];
      4'd7:    data_byte = height32[7:0];
      4'd8:    data_byte = {3'b000, sample_depth_i};
      4'd9:    data_byte = {5'b00000, colour_kind_i};
      default: data_byte = 8'h00;
    endcase
  end

  assign crc_next = crc_byte(crc_q, data_byte);

  // Restart on every header write, finish after the last data byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      crc_q    <= CRC_AFTER_IHDR;
      result_q <= RST_IHDR_CRC;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      crc_q  <= CRC_AFTER_IHDR;
    end else if (busy_q) begin
      crc_q <= crc_next;
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == LAST_BYTE) begin
        busy_q   <= 1'b0;
        result_q <= crc_next ^ CRC_ALL_ONES;
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.crc  = result_q;

endmodule

`default_nettype wire

@@ rtl/png_chunk_stream_assembler_core.sv @@
// An accepted byte is held in the input stage; its beats go from there into the
// output register. A mid-image byte gives one beat; the first byte of an image
// gives 23 beats (27 if it also ends the image), the last byte 5 beats: the
// output register loads one 4-byte beat per cycle unless the output stalls.
// Reset: default configuration, no image open. A write to a header field
// rebuilds the IHDR checksum; input is stalled meanwhile.
`default_nettype none

module png_chunk_stream_assembler_core
  import pngc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output      logic                  cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // compressed byte input
  input  wire logic                  in_valid_i,
  output      logic                  in_stall_o,
  input  wire logic [7:0]            data_byte_i,
  // file byte output
  output      logic                  out_valid_o,
  input  wire logic                  out_stall_i,
  output      logic [31:0]           packed_bytes_o,
  output      logic [2:0]            byte_count_o,
  output      logic                  run_end_o,
  output      logic                  file_end_o
);

  // Final beat index for each kind of byte
  localparam logic [4:0] LAST_GRP_MID        = 5'd0;
  localparam logic [4:0] LAST_GRP_END        = 5'd4;
  localparam logic [4:0] LAST_GRP_START      = 5'd22;
  localparam logic [4:0] LAST_GRP_START_END  = 5'd26;

  // Configuration registers
  logic [DIM_W-1:0]    image_width_q;
  logic [DIM_W-1:0]    image_height_q;
  logic [DEPTH_W-1:0]  sample_depth_q;
  logic [COLOUR_W-1:0] colour_kind_q;
  logic [DIM_W-1:0]    payload_length_q;
  logic                cfg_acc;
  logic                hdr_start;
  ihdr_crc_t           hdr_status;

  // Image state
  logic                image_open_q;
  logic [DIM_W-1:0]    bytes_seen_q;
  logic [31:0]         run_crc_q;

  // Input stage: the byte whose beats are being emitted
  logic                a_valid_q;
  logic [7:0]          a_byte_q;
  logic                a_first_q;
  logic                a_last_q;
  logic [31:0]         a_crc_q;
  logic [4:0]          g_q;

  // Output register
  logic                out_valid_q;
  logic [31:0]         out_word_q;
  logic [2:0]          out_count_q;
  logic                out_run_end_q;
  logic                out_file_end_q;

  logic                in_acc;
  logic                load;
  logic                last_grp;
  logic [4:0]          last_grp_idx;
  logic [DIM_W-1:0]    eff_len;
  logic [DIM_W-1:0]    seen_next;
  logic                byte_ends;
  logic [31:0]         crc_start;
  logic [31:0]         crc_new;
  logic [31:0]         grp_word;
  logic [2:0]          grp_count;
  logic [31:0]         len32;
  logic [31:0]         width32;
  logic [31:0]         height32;

  // Configuration port: always ready
  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i;
  assign hdr_start   = cfg_acc && (cfg_index_i inside {[REG_IMAGE_WIDTH:REG_COLOUR_KIND]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q    <= RST_IMAGE_WIDTH;
      image_height_q   <= RST_IMAGE_HEIGHT;
      sample_depth_q   <= RST_SAMPLE_DEPTH;
      colour_kind_q    <= RST_COLOUR_KIND;
      payload_length_q <= RST_PAYLOAD_LENGTH;
    end else if (cfg_acc) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:    image_width_q    <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT:   image_height_q   <= cfg_data_i[DIM_W-1:0];
        REG_SAMPLE_DEPTH:   sample_depth_q   <= cfg_data_i[DEPTH_W-1:0];
        REG_COLOUR_KIND:    colour_kind_q    <= cfg_data_i[COLOUR_W-1:0];
        REG_PAYLOAD_LENGTH: payload_length_q <= cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  pngc_ihdr_crc u_ihdr_crc (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (hdr_start),
    .image_width_i  (image_width_q),
    .image_height_i (image_height_q),
    .sample_depth_i (sample_depth_q),
    .colour_kind_i  (colour_kind_q),
    .status_o       (hdr_status)
  );

  // Zero length counts as one byte
  assign eff_len = (payload_length_q == '0) ? {{(DIM_W-1){1'b0}}, 1'b1} : payload_length_q;

  // Classify the incoming byte and advance the IDAT checksum
  assign seen_next = (image_open_q ? bytes_seen_q : '0) + {{(DIM_W-1){1'b0}}, 1'b1};
  assign byte_ends = (seen_next >= eff_len);
  assign crc_start = image_open_q ? run_crc_q : CRC_AFTER_IDAT;
  assign crc_new   = crc_byte(crc_start, data_byte_i);

  // Beat sequencing
  always_comb begin
    case ({a_first_q, a_last_q})
      2'b11:   last_grp_idx = LAST_GRP_START_END;
      2'b10:   last_grp_idx = LAST_GRP_START;
      2'b01:   last_grp_idx = LAST_GRP_END;
      default: last_grp_idx = LAST_GRP_MID;
    endcase
  end

  assign last_grp   = (g_q == last_grp_idx);
  assign load       = a_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = hdr_status.busy || (a_valid_q && !(load && last_grp));
  assign in_acc     = in_valid_i && !in_stall_o;

  // Hold image state; update it on every accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_open_q <= 1'b0;
      bytes_seen_q <= '0;
      run_crc_q    <= CRC_ALL_ONES;
    end else if (in_acc) begin
      image_open_q <= !byte_ends;
      bytes_seen_q <= byte_ends ? '0 : seen_next;
      run_crc_q    <= byte_ends ? CRC_ALL_ONES : crc_new;
    end
  end

  // Input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      g_q       <= '0;
    end else begin
      if (in_acc) begin
        a_valid_q <= 1'b1;
      end else if (load && last_grp) begin
        a_valid_q <= 1'b0;
      end
      if (load) begin
        g_q <= last_grp ? '0 : g_q + 5'd1;
      end
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_byte_q  <= data_byte_i;
      a_first_q <= !image_open_q;
      a_last_q  <= byte_ends;
      a_crc_q   <= crc_new ^ CRC_ALL_ONES;
    end
  end

  // Build the beat at the current position of the file byte stream
  assign len32    = {1'b0, eff_len};
  assign width32  = {1'b0, image_width_q};
  assign height32 = {1'b0, image_height_q};

  always_comb begin
    if (a_first_q) begin
      case (g_q)
        5'd0:    grp_word = 32'h8950_4E47;
        5'd1:    grp_word = 32'h0D0A_1A0A;
        5'd2:    grp_word = 32'h0000_000D;
        5'd3:    grp_word = TAG_IHDR;
        5'd4:    grp_word = width32;
        5'd5:    grp_word = height32;
        5'd6:    grp_word = {3'b000, sample_depth_q, 5'b00000, colour_kind_q, 16'h0000};
        5'd7:    grp_word = {8'h00, hdr_status.crc[31:8]};
        5'd8:    grp_word = {hdr_status.crc[7:0], 24'h00_0000};
        5'd9:    grp_word = 32'h0173_5247;
        5'd10:   grp_word = {16'h4200, SRGB_CRC[31:16]};
        5'd11:   grp_word = {SRGB_CRC[15:0], 16'h0000};
        5'd12:   grp_word = 32'h0004_6741;
        5'd13:   grp_word = 32'h4D41_0000;
        5'd14:   grp_word = {16'hB18F, GAMA_CRC[31:16]};
        5'd15:   grp_word = {GAMA_CRC[15:0], 16'h0000};
        5'd16:   grp_word = 32'h0009_7048;
        5'd17:   grp_word = 32'h5973_0000;
        5'd18:   grp_word = 32'h0EC3_0000;
        5'd19:   grp_word = {24'h0EC3_01, PHYS_CRC[31:24]};
        5'd20:   grp_word = {PHYS_CRC[23:0], len32[31:24]};
        5'd21:   grp_word = {len32[23:0], TAG_IDAT[31:24]};
        5'd22:   grp_word = {TAG_IDAT[23:0], a_byte_q};
        5'd23:   grp_word = a_crc_q;
        5'd24:   grp_word = 32'h0000_0000;
        5'd25:   grp_word = TAG_IEND;
        5'd26:   grp_word = IEND_CRC;
        default: grp_word = 32'h0000_0000;
      endcase
    end else begin
      case (g_q)
        5'd0:    grp_word = a_last_q ? {a_byte_q, a_crc_q[31:8]} : {a_byte_q, 24'h00_0000};
        5'd1:    grp_word = {a_crc_q[7:0], 24'h00_0000};
        5'd2:    grp_word = {8'h00, TAG_IEND[31:8]};
        5'd3:    grp_word = {TAG_IEND[7:0], IEND_CRC[31:8]};
        5'd4:    grp_word = {IEND_CRC[7:0], 24'h00_0000};
        default: grp_word = 32'h0000_0000;
      endcase
    end
  end

  // Only a continuing byte can leave a short final beat
  assign grp_count = (!a_first_q && last_grp) ? 3'd1 : 3'd4;

  // Output register: load a beat whenever the slot is free or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q     <= grp_word;
      out_count_q    <= grp_count;
      out_run_end_q  <= last_grp;
      out_file_end_q <= last_grp && a_last_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign packed_bytes_o = out_word_q;
  assign byte_count_o   = out_count_q;
  assign run_end_o      = out_run_end_q;
  assign file_end_o     = out_file_end_q;

endmodule

`default_nettype wire

@@ rtl/pngc_checker.sv @@
// Port-level checker for the PNG chunk stream assembler, bound to png_chunk_stream_assembler_core.
// Depends on pngc_pkg.
`default_nettype none

module pngc_checker
  import pngc_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [31:0]           packed_bytes_o,
  input wire logic [2:0]            byte_count_o,
  input wire logic                  run_end_o,
  input wire logic                  file_end_o
);

  // Beats are full except a single trailing byte
  a_count_one_or_four: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_count_o == 3'd1 || byte_count_o == 3'd4))
    else $error("byte_count outside 1 or 4");

  // A short beat carries zeros below its single byte
  a_short_beat_padded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && byte_count_o == 3'd1) |-> (packed_bytes_o[23:0] == 24'h00_0000))
    else $error("short beat has nonzero padding");

  // The file ends on the IEND checksum and closes the run
  a_file_end_iend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && file_end_o) |-> (run_end_o &&
      ((byte_count_o == 3'd4 && packed_bytes_o == IEND_CRC) ||
       (byte_count_o == 3'd1 && packed_bytes_o == {IEND_CRC[7:0], 24'h00_0000}))))
    else $error("file_end without IEND checksum");

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(packed_bytes_o)
      && $stable(byte_count_o) && $stable(file_end_o)))
    else $error("stalled output beat changed");

endmodule

bind png_chunk_stream_assembler_core pngc_checker u_pngc_checker (.*);

`default_nettype wire

@@ verif/png_chunk_stream_assembler_core_tb.sv @@
// Self-checking testbench for png_chunk_stream_assembler_core: directed table, then random
// images under bursty input, random output stall and one long output hold-off.
// Depends on rtl/pngc_pkg.sv and rtl/png_chunk_stream_assembler_core.sv.
`default_nettype none

module testbench
  import pngc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // PNG framing constants
  localparam logic [63:0] PNG_SIGNATURE = 64'h8950_4E47_0D0A_1A0A;
  localparam logic [31:0] CHUNK_IHDR    = 32'h4948_4452;
  localparam logic [31:0] CHUNK_SRGB    = 32'h7352_4742;
  localparam logic [31:0] CHUNK_GAMA    = 32'h6741_4D41;
  localparam logic [31:0] CHUNK_PHYS    = 32'h7048_5973;
  localparam logic [31:0] CHUNK_IDAT    = 32'h4944_4154;
  localparam logic [31:0] CHUNK_IEND    = 32'h4945_4E44;
  localparam logic [31:0] GAMMA_E5      = 32'd45455;
  localparam logic [31:0] PIX_PER_M     = 32'd3779;
  localparam logic [31:0] CRC32_ONES    = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC32_POLY_R  = 32'hEDB8_8320;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam int RANDOM_BYTES = 380;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        run_last;
    logic        file_last;
  } file_beat_t;

  typedef struct {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          value;
    logic                 typed;
    file_beat_t           beat;
  } stim_row_t;

  // DUT signals
  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [31:0]           packed_bytes_o;
  logic [2:0]            byte_count_o;
  logic                  run_end_o;
  logic                  file_end_o;

  // Sideband travelling with each input beat: typed-in first result
  logic       side_chk;
  file_beat_t side_beat;

  // Predictor copy of the configuration and the stream state
  logic [30:0] cur_width  = 31'd1;
  logic [30:0] cur_height = 31'd1;
  logic [4:0]  cur_depth  = 5'd8;
  logic [2:0]  cur_colour = 3'd6;
  logic [30:0] cur_length = 31'd1;
  logic [30:0] seen_cnt   = 31'd0;
  logic [31:0] idat_crc   = CRC32_ONES;
  logic        hdr_sent   = 1'b0;

  logic [7:0] step_bytes[$];
  file_beat_t beats_due[$];
  file_beat_t due;
  int         err_cnt = 0;
  int         burst_left = 0;

  // Receiver pacing
  logic hold_req  = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;
  int   mode_left = 0;
  int   stall_pct = 0;

  stim_row_t plan[$];

  png_chunk_stream_assembler_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packed_bytes_o (packed_bytes_o),
    .byte_count_o   (byte_count_o),
    .run_end_o      (run_end_o),
    .file_end_o     (file_end_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Reflected CRC-32, one byte
  function automatic logic [31:0] crc32_update(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    repeat (8) r = {1'b0, r[31:1]} ^ (r[0] ? CRC32_POLY_R : 32'd0);
    return r;
  endfunction

  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) step_bytes.push_back(w[8*i +: 8]);
  endtask

  // Length, tag, body (first byte at the top of body), CRC over tag and body
  task automatic put_chunk(input logic [31:0] tag, input logic [103:0] body, input int n);
    logic [31:0] c;
    logic [7:0]  b;
    c = CRC32_ONES;
    put_word(n);
    for (int i = 3; i >= 0; i--) begin
      b = tag[8*i +: 8];
      step_bytes.push_back(b);
      c = crc32_update(c, b);
    end
    for (int i = 0; i < n; i++) begin
      b = body[103-8*i -: 8];
      step_bytes.push_back(b);
      c = crc32_update(c, b);
    end
    put_word(~c);
  endtask

  // Work out the file beats caused by one payload byte and queue them
  task automatic predict_file_beats(input logic [7:0] b, input logic chk,
                                    input file_beat_t typed);
    logic [30:0] eff;
    logic        last_file;
    int          base;
    int          total;
    int          cnt;
    logic [31:0] w;
    file_beat_t  nb;
    step_bytes.delete();
    last_file = 1'b0;
    eff = (cur_length == 31'd0) ? 31'd1 : cur_length;
    // Open a new image: signature, fixed chunks, IDAT length and type
    if (!hdr_sent) begin
      for (int i = 7; i >= 0; i--) step_bytes.push_back(PNG_SIGNATURE[8*i +: 8]);
      put_chunk(CHUNK_IHDR, {1'b0, cur_width, 1'b0, cur_height, 3'b000, cur_depth,
                             5'b00000, cur_colour, 24'h0}, 13);
      put_chunk(CHUNK_SRGB, 104'h0, 1);
      put_chunk(CHUNK_GAMA, {GAMMA_E5, 72'h0}, 4);
      put_chunk(CHUNK_PHYS, {PIX_PER_M, PIX_PER_M, 8'h01, 32'h0}, 9);
      put_word({1'b0, eff});
      idat_crc = CRC32_ONES;
      for (int i = 3; i >= 0; i--) begin
        step_bytes.push_back(CHUNK_IDAT[8*i +: 8]);
        idat_crc = crc32_update(idat_crc, CHUNK_IDAT[8*i +: 8]);
      end
      seen_cnt = 31'd0;
      hdr_sent = 1'b1;
    end
    step_bytes.push_back(b);
    idat_crc = crc32_update(idat_crc, b);
    seen_cnt = seen_cnt + 31'd1;
    // Close the image: IDAT CRC and IEND
    if (seen_cnt >= eff) begin
      put_word(~idat_crc);
      put_chunk(CHUNK_IEND, 104'h0, 0);
      seen_cnt  = 31'd0;
      idat_crc  = CRC32_ONES;
      hdr_sent  = 1'b0;
      last_file = 1'b1;
    end
    // Pack back to back, first byte on top
    base  = beats_due.size();
    total = step_bytes.size();
    for (int k = 0; k < total; k += 4) begin
      cnt = (total - k > 4) ? 4 : total - k;
      w = 32'd0;
      for (int j = 0; j < 4; j++) w = {w[23:0], (j < cnt) ? step_bytes[k+j] : 8'h00};
      nb.word      = w;
      nb.cnt       = cnt[2:0];
      nb.run_last  = (k + 4 >= total);
      nb.file_last = (k + 4 >= total) && last_file;
      beats_due.push_back(nb);
    end
    if (chk) beats_due[base] = typed;
  endtask

  // Track accepted register writes and input beats
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_IMAGE_WIDTH:    cur_width  = cfg_data_i[30:0];
        REG_IMAGE_HEIGHT:   cur_height = cfg_data_i[30:0];
        REG_SAMPLE_DEPTH:   cur_depth  = cfg_data_i[4:0];
        REG_COLOUR_KIND:    cur_colour = cfg_data_i[2:0];
        REG_PAYLOAD_LENGTH: cur_length = cfg_data_i[30:0];
        default: ;
      endcase
    end
    if (rst_ni && in_valid_i && !in_stall_o) begin
      predict_file_beats(data_byte_i, side_chk, side_beat);
    end
  end

  // Compare each accepted output beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (beats_due.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat, expected none, actual %h/%0d/%b/%b", $time,
                 packed_bytes_o, byte_count_o, run_end_o, file_end_o);
      end else begin
        due = beats_due.pop_front();
        if (packed_bytes_o !== due.word) begin
          err_cnt++;
          $display("%0t: packed_bytes expected %h actual %h", $time, due.word,
                   packed_bytes_o);
        end
        if (byte_count_o !== due.cnt) begin
          err_cnt++;
          $display("%0t: byte_count expected %0d actual %0d", $time, due.cnt,
                   byte_count_o);
        end
        if (run_end_o !== due.run_last) begin
          err_cnt++;
          $display("%0t: run_end expected %b actual %b", $time, due.run_last, run_end_o);
        end
        if (file_end_o !== due.file_last) begin
          err_cnt++;
          $display("%0t: file_end expected %b actual %b", $time, due.file_last,
                   file_end_o);
        end
      end
    end
  end

  // Receiver: one long hold-off on request, otherwise stall at a rate that changes
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_left   <= HOLD_CYCLES;
      hold_done   <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(16, 96);
        case ($urandom_range(0, 4))
          0:       stall_pct <= 0;
          1:       stall_pct <= 10;
          2:       stall_pct <= 30;
          3:       stall_pct <= 60;
          default: stall_pct <= 90;
        endcase
      end else begin
        mode_left <= mode_left - 1;
      end
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  function automatic stim_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
    stim_row_t r;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = v;
    r.typed  = 1'b0;
    r.beat   = '0;
    return r;
  endfunction

  function automatic stim_row_t byte_row(logic [7:0] b);
    stim_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = REG_IMAGE_WIDTH;
    r.value  = {24'd0, b};
    r.typed  = 1'b0;
    r.beat   = '0;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [7:0] b, logic [31:0] w, logic [2:0] n,
                                          logic rl, logic fl);
    stim_row_t r;
    r = byte_row(b);
    r.typed = 1'b1;
    r.beat  = {w, n, rl, fl};
    return r;
  endfunction

  // Write one register once every expected beat has come out
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (beats_due.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  // Offer one payload beat; insert a random gap between bursts
  task automatic send_byte(input logic [7:0] b, input logic chk, input file_beat_t typed);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    side_chk    <= chk;
    side_beat   <= typed;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
  endtask

  initial begin
    int sent;
    int n;
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_IMAGE_WIDTH;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    data_byte_i = 8'h00;
    side_chk    = 1'b0;
    side_beat   = '0;
    sent        = 0;

    // Directed table
    // Reset settings: one-byte images, so the first byte carries the whole file
    plan.push_back(known_row(8'h00, 32'h8950_4E47, 3'd4, 1'b0, 1'b0));
    plan.push_back(reg_row(REG_PAYLOAD_LENGTH, 32'd3));
    plan.push_back(known_row(8'hFF, 32'h8950_4E47, 3'd4, 1'b0, 1'b0));
    plan.push_back(known_row(8'h00, 32'h0000_0000, 3'd1, 1'b1, 1'b0));
    plan.push_back(byte_row(8'hFF));
    // Register extremes, bits above each field set; zero length acts as one
    plan.push_back(reg_row(REG_IMAGE_WIDTH, 32'hFFFF_FFFF));
    plan.push_back(reg_row(REG_IMAGE_HEIGHT, 32'h8000_0000));
    plan.push_back(reg_row(REG_SAMPLE_DEPTH, 32'hFFFF_FFFF));
    plan.push_back(reg_row(REG_COLOUR_KIND, 32'hFFFF_FFFF));
    plan.push_back(reg_row(REG_PAYLOAD_LENGTH, 32'h0000_0000));
    plan.push_back(byte_row(8'hA5));
    // Out-of-range header fields and the largest length
    plan.push_back(reg_row(REG_IMAGE_WIDTH, 32'd0));
    plan.push_back(reg_row(REG_IMAGE_HEIGHT, 32'h7FFF_FFFF));
    plan.push_back(reg_row(REG_SAMPLE_DEPTH, 32'd0));
    plan.push_back(reg_row(REG_COLOUR_KIND, 32'd0));
    plan.push_back(reg_row(REG_PAYLOAD_LENGTH, 32'h7FFF_FFFF));
    plan.push_back(byte_row(8'h5A));
    plan.push_back(known_row(8'h80, 32'h8000_0000, 3'd1, 1'b1, 1'b0));
    plan.push_back(known_row(8'h01, 32'h0100_0000, 3'd1, 1'b1, 1'b0));
    // Mid-image changes: header fields wait for the next image, length ends it now
    plan.push_back(reg_row(REG_IMAGE_WIDTH, 32'd640));
    plan.push_back(reg_row(REG_IMAGE_HEIGHT, 32'd480));
    plan.push_back(reg_row(REG_SAMPLE_DEPTH, 32'd16));
    plan.push_back(reg_row(REG_COLOUR_KIND, 32'd6));
    plan.push_back(reg_row(REG_PAYLOAD_LENGTH, 32'd2));
    plan.push_back(byte_row(8'h7F));
    plan.push_back(byte_row(8'h3C));
    plan.push_back(byte_row(8'hC3));
    // Unused register index is ignored
    plan.push_back(reg_row(REG_SPARE, 32'hFFFF_FFFF));
    plan.push_back(reg_row(REG_SAMPLE_DEPTH, 32'd8));
    plan.push_back(reg_row(REG_PAYLOAD_LENGTH, 32'd1));
    plan.push_back(byte_row(8'h10));
    plan.push_back(byte_row(8'h20));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_byte(plan[i].value[7:0], plan[i].typed, plan[i].beat);
      end
    end

    // Random images; hold the receiver off once while bytes keep coming
    hold_req <= 1'b1;
    while (sent < RANDOM_BYTES) begin
      // Skip register writes until the hold-off is over so bytes pile up behind it
      if (hold_done && hold_left == 0 && $urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 9))
          0:       write_reg(REG_PAYLOAD_LENGTH, 32'd0);
          1:       write_reg(REG_PAYLOAD_LENGTH, 32'hFFFF_FFFF);
          2, 3:    write_reg(REG_PAYLOAD_LENGTH, 32'd1);
          4, 5, 6: write_reg(REG_PAYLOAD_LENGTH, $urandom_range(2, 6));
          default: write_reg(REG_PAYLOAD_LENGTH, $urandom_range(7, 30));
        endcase
      end
      if (hold_done && hold_left == 0 && $urandom_range(0, 2) == 0) begin
        write_reg(REG_IMAGE_WIDTH, ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom);
        write_reg(REG_IMAGE_HEIGHT, ($urandom_range(0, 3) == 0) ? 32'd1 : $urandom);
        case ($urandom_range(0, 3))
          0:       write_reg(REG_SAMPLE_DEPTH, 32'd8);
          1:       write_reg(REG_SAMPLE_DEPTH, 32'd16);
          default: write_reg(REG_SAMPLE_DEPTH, $urandom);
        endcase
        case ($urandom_range(0, 3))
          0:       write_reg(REG_COLOUR_KIND, 32'd0);
          1:       write_reg(REG_COLOUR_KIND, 32'd6);
          default: write_reg(REG_COLOUR_KIND, $urandom);
        endcase
      end
      n = $urandom_range(6, 40);
      repeat (n) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
        sent++;
      end
    end

    // Drain, then watch for stray beats
    in_valid_i <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("png_chunk_stream_assembler_core verification clean");
    end else begin
      $display("png_chunk_stream_assembler_core verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("png_chunk_stream_assembler_core verification failed");
    $finish;
  end

endmodule

`default_nettype wire
